/* hdl/plcm_pkg.sv */
// Package with shared types, codes and constants of the profile line cut block.
`default_nettype none

package plcm_pkg;

  localparam int unsigned MAX_SLICES_DEF = 256;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned SLICE_W  = 18;
  localparam int unsigned NUM_W    = 34;
  localparam int unsigned DIVISOR_W = 16;
  localparam int unsigned QMAG_W   = 17;
  localparam int unsigned DIV_STEPS = QMAG_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int unsigned STEP_W   = 10;
  localparam int unsigned SIU_W    = 9;
  localparam int unsigned IRAD_W   = 15;
  localparam int unsigned CHG_W    = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [STEP_W-1:0] STEP_RST = 10'd1;
  localparam logic [SIU_W-1:0]  SIU_RST  = 9'd256;
  localparam logic signed [COORD_W-1:0] RADIUS_RST = 16'sd100;

  typedef enum logic [1:0] {
    FUNC_CUT     = 2'd0,
    FUNC_RESTORE = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLICE_STEP     = 2'd0,
    CFG_SLICES_IN_USE  = 2'd1,
    CFG_INITIAL_RADIUS = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_S1,
    ST_WAIT_S1,
    ST_DIV_S2,
    ST_WAIT_S2,
    ST_ORDER,
    ST_SPAN,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_DIV_Y,
    ST_WAIT_Y,
    ST_SAME_WAIT,
    ST_SAME_CMP,
    ST_RD_WAIT,
    ST_RD_FIN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic                     start;
    logic signed [NUM_W-1:0]  dividend;
    logic [DIVISOR_W-1:0]     divisor;
  } div_req_t;

endpackage

`default_nettype wire

/* hdl/plcm_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module plcm_div
  import plcm_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire div_req_t                   req_i,
  output logic                            done_o,
  output logic signed [COORD_W-1:0]       quot_o
);

  logic                   run_q, run_d;
  logic                   done_q, done_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]   rem_q, rem_d;
  logic [QMAG_W-1:0]      qsr_q, qsr_d;
  logic                   neg_q, neg_d;
  logic [DIVISOR_W-1:0]   div_q, div_d;
  logic [NUM_W-1:0]       mag;
  logic [DIVISOR_W:0]     trial;
  logic                   ge;
  logic [QMAG_W-1:0]      qneg;

  // The quotient magnitude never exceeds 2^17 - 1, so the upper dividend bits
  // already lie below the divisor and seed the remainder.
  always_comb begin
    mag    = req_i.dividend[NUM_W-1] ? NUM_W'(-req_i.dividend) : req_i.dividend;
    trial  = {rem_q, qsr_q[QMAG_W-1]};
    ge     = trial >= {1'b0, div_q};
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    qsr_d  = qsr_q;
    neg_d  = neg_q;
    div_d  = div_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = DIV_CNT_W'(DIV_STEPS - 1);
      rem_d = {1'b0, mag[31:QMAG_W]};
      qsr_d = mag[QMAG_W-1:0];
      neg_d = req_i.dividend[NUM_W-1];
      div_d = req_i.divisor;
    end else if (run_q) begin
      rem_d = ge ? DIVISOR_W'(trial - {1'b0, div_q}) : trial[DIVISOR_W-1:0];
      qsr_d = {qsr_q[QMAG_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    qsr_q <= qsr_d;
    neg_q <= neg_d;
    div_q <= div_d;
  end

  assign qneg   = QMAG_W'(-qsr_q);
  assign done_o = done_q;
  assign quot_o = neg_q ? $signed(qneg[COORD_W-1:0]) : $signed(qsr_q[COORD_W-1:0]);

  a_no_start_while_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !run_q)
    else $error("Divider started while a division is running.");

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(run_q))
    else $error("Divider finished without running.");

endmodule

`default_nettype wire

/* hdl/profile_line_cut_min_update.sv */
// Top level of the radius profile keeper: sequencer, profile memory and result register.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid_i/tready_o     tuser func, tdata both endpoints
//   m_axis    out  m_axis_tvalid_o/tready_i     tdata read_radius, slices_changed
//   cfg       in   cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// A cut runs two divisions for the slice numbers, the setup steps ORDER, SPAN, MUL_A, MUL_B
// and SUM, then one division per slice walked, all on the shared one-bit-per-cycle divider;
// a cut within one slice compares that slice alone. A read passes RD_WAIT and RD_FIN, a
// restore refills every slice in CLEAR. After reset a fill pass loads every slice before the
// first request is taken. A waiting result does not block the next request.
`default_nettype none

module profile_line_cut_min_update
  import plcm_pkg::*;
#(
  parameter int unsigned MAX_SLICES = MAX_SLICES_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [15:0] first_x, [31:16] first_y, [47:32] second_x, [63:48] second_y
  input  wire logic [63:0]              s_axis_tdata_i,
  // [1:0] func
  input  wire logic [1:0]               s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  wire logic                     m_axis_tready_i,
  // [15:0] read_radius, [24:16] slices_changed, [31:25] zero
  output logic [31:0]                   m_axis_tdata_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned IDX_W = $clog2(MAX_SLICES);

  state_e state_q, state_d;

  logic [STEP_W-1:0]  step_q;
  logic [SIU_W-1:0]   siu_q;
  logic [IRAD_W-1:0]  irad_q;

  logic                         out_valid_q, out_valid_d;
  logic signed [COORD_W-1:0]    out_rad_q, out_rad_d;
  logic [CHG_W-1:0]             out_chg_q, out_chg_d;
  logic                         reply_q, reply_d;
  logic signed [COORD_W-1:0]    fill_q, fill_d;
  logic [IDX_W-1:0]             clr_q, clr_d;

  logic signed [COORD_W-1:0]    x1_q, x1_d, y1_q, y1_d, x2_q, x2_d, y2_q, y2_d;
  logic signed [COORD_W-1:0]    s1_q, s1_d, s2_q, s2_d;
  logic signed [SLICE_W-1:0]    xs_q, xs_d, xe_q, xe_d;
  logic signed [COORD_W-1:0]    ys_q, ys_d, ye_q, ye_d;
  logic [DIVISOR_W-1:0]         dx_q, dx_d, k_q, k_d;
  logic signed [COORD_W:0]      dy_q, dy_d;
  logic signed [SLICE_W-1:0]    s_q, s_d, hi_q, hi_d;
  logic signed [NUM_W-1:0]      prod_q, prod_d, num_q, num_d;
  logic [CHG_W-1:0]             cnt_q, cnt_d;
  logic signed [COORD_W-1:0]    rad_q, rad_d;

  logic signed [COORD_W-1:0]    mem [MAX_SLICES];
  logic signed [COORD_W-1:0]    rdata_q;
  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr;
  logic signed [COORD_W-1:0]    mem_wdata;

  logic signed [SLICE_W-1:0]    live_s;
  logic signed [SLICE_W-1:0]    lo, hi, s_in;
  logic                         s_ok;
  logic signed [COORD_W:0]      mul_a, mul_b;
  logic signed [NUM_W-1:0]      mul_p;
  logic [DIVISOR_W-1:0]         step_div;

  div_req_t                     div_req;
  logic                         div_done;
  logic signed [COORD_W-1:0]    div_quot;
  logic                         accept;

  plcm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign live_s   = ({9'd0, siu_q} > SLICE_W'(MAX_SLICES)) ? SLICE_W'(MAX_SLICES)
                                                            : $signed({9'd0, siu_q});
  assign step_div = (step_q == '0) ? DIVISOR_W'(1) : DIVISOR_W'(step_q);
  assign mul_p    = NUM_W'(mul_a) * NUM_W'(mul_b);
  assign s_ok     = (s_q >= 0) && (s_q < live_s);
  assign lo       = (xs_q < 0) ? SLICE_W'(0) : xs_q;
  assign hi       = (xe_q < live_s - SLICE_W'(1)) ? xe_q : live_s - SLICE_W'(1);
  assign s_in     = SLICE_W'(s1_q);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RST;
      siu_q  <= SIU_RST;
      irad_q <= IRAD_W'(RADIUS_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLICE_STEP:     step_q <= cfg_wdata_i[STEP_W-1:0];
        CFG_SLICES_IN_USE:  siu_q  <= cfg_wdata_i[SIU_W-1:0];
        CFG_INITIAL_RADIUS: irad_q <= cfg_wdata_i[IRAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_rad_d   = out_rad_q;
    out_chg_d   = out_chg_q;
    reply_d     = reply_q;
    fill_d      = fill_q;
    clr_d       = clr_q;
    x1_d = x1_q;  y1_d = y1_q;  x2_d = x2_q;  y2_d = y2_q;
    s1_d = s1_q;  s2_d = s2_q;
    xs_d = xs_q;  xe_d = xe_q;  ys_d = ys_q;  ye_d = ye_q;
    dx_d = dx_q;  dy_d = dy_q;  k_d = k_q;
    s_d  = s_q;   hi_d = hi_q;
    prod_d = prod_q;  num_d = num_q;
    cnt_d  = cnt_q;   rad_d = rad_q;
    mul_a  = '0;
    mul_b  = '0;
    div_req = '0;
    mem_we    = 1'b0;
    mem_waddr = s_q[IDX_W-1:0];
    mem_wdata = ys_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = fill_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == IDX_W'(MAX_SLICES - 1)) begin
          state_d = reply_q ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          x1_d  = $signed(s_axis_tdata_i[15:0]);
          y1_d  = $signed(s_axis_tdata_i[31:16]);
          x2_d  = $signed(s_axis_tdata_i[47:32]);
          y2_d  = $signed(s_axis_tdata_i[63:48]);
          s_d   = SLICE_W'($signed(s_axis_tdata_i[15:0]));
          cnt_d = '0;
          rad_d = '0;
          case (func_e'(s_axis_tuser_i))
            FUNC_CUT:     state_d = ST_DIV_S1;
            FUNC_RESTORE: begin
              fill_d  = $signed({1'b0, irad_q});
              clr_d   = '0;
              reply_d = 1'b1;
              state_d = ST_CLEAR;
            end
            FUNC_READ:    state_d = ST_RD_WAIT;
            default:      state_d = ST_RESP;
          endcase
        end
      end
      ST_DIV_S1: begin
        div_req.start    = 1'b1;
        div_req.dividend = NUM_W'(x1_q);
        div_req.divisor  = step_div;
        state_d          = ST_WAIT_S1;
      end
      ST_WAIT_S1: begin
        if (div_done) begin
          s1_d    = div_quot;
          state_d = ST_DIV_S2;
        end
      end
      ST_DIV_S2: begin
        div_req.start    = 1'b1;
        div_req.dividend = NUM_W'(x2_q);
        div_req.divisor  = step_div;
        state_d          = ST_WAIT_S2;
      end
      ST_WAIT_S2: begin
        if (div_done) begin
          s2_d    = div_quot;
          state_d = ST_ORDER;
        end
      end
      ST_ORDER: begin
        if (s1_q == s2_q) begin
          s_d  = s_in;
          ys_d = (y1_q < y2_q) ? y1_q : y2_q;
          state_d = ((s_in >= 0) && (s_in < live_s)) ? ST_SAME_WAIT : ST_RESP;
        end else begin
          if (s1_q < s2_q) begin
            xs_d = SLICE_W'(s1_q);  ys_d = y1_q;
            xe_d = SLICE_W'(s2_q);  ye_d = y2_q;
          end else begin
            xs_d = SLICE_W'(s2_q);  ys_d = y2_q;
            xe_d = SLICE_W'(s1_q);  ye_d = y1_q;
          end
          state_d = ST_SPAN;
        end
      end
      ST_SPAN: begin
        s_d  = lo;
        hi_d = hi;
        dx_d = DIVISOR_W'(xe_q - xs_q);
        dy_d = (COORD_W + 1)'(ye_q) - (COORD_W + 1)'(ys_q);
        k_d  = DIVISOR_W'(lo - xs_q);
        state_d = ST_MUL_A;
      end
      ST_MUL_A: begin
        if (s_q > hi_q) begin
          state_d = ST_RESP;
        end else begin
          mul_a   = (COORD_W + 1)'(ys_q);
          mul_b   = $signed({1'b0, dx_q});
          prod_d  = mul_p;
          state_d = ST_MUL_B;
        end
      end
      ST_MUL_B: begin
        num_d   = prod_q;
        mul_a   = dy_q;
        mul_b   = $signed({1'b0, k_q});
        prod_d  = mul_p;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        num_d   = num_q + prod_q;
        state_d = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        div_req.start    = 1'b1;
        div_req.dividend = num_q;
        div_req.divisor  = dx_q;
        state_d          = ST_WAIT_Y;
      end
      ST_WAIT_Y: begin
        if (div_done) begin
          mem_wdata = div_quot;
          if (rdata_q > div_quot) begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + 1'b1;
          end
          if (s_q == hi_q) begin
            state_d = ST_RESP;
          end else begin
            s_d     = s_q + 1'b1;
            num_d   = num_q + NUM_W'(dy_q);
            state_d = ST_DIV_Y;
          end
        end
      end
      ST_SAME_WAIT: state_d = ST_SAME_CMP;
      ST_SAME_CMP: begin
        if (rdata_q > ys_q) begin
          mem_we = 1'b1;
          cnt_d  = CHG_W'(1);
        end
        state_d = ST_RESP;
      end
      ST_RD_WAIT: state_d = ST_RD_FIN;
      ST_RD_FIN: begin
        if (s_ok) begin
          rad_d = rdata_q;
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_rad_d   = rad_q;
          out_chg_d   = cnt_q;
          reply_d     = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
      reply_q     <= 1'b0;
      fill_q      <= RADIUS_RST;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      reply_q     <= reply_d;
      fill_q      <= fill_d;
      clr_q       <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rad_q <= out_rad_d;
    out_chg_q <= out_chg_d;
    x1_q <= x1_d;  y1_q <= y1_d;  x2_q <= x2_d;  y2_q <= y2_d;
    s1_q <= s1_d;  s2_q <= s2_d;
    xs_q <= xs_d;  xe_q <= xe_d;  ys_q <= ys_d;  ye_q <= ye_d;
    dx_q <= dx_d;  dy_q <= dy_d;  k_q <= k_d;
    s_q  <= s_d;   hi_q <= hi_d;
    prod_q <= prod_d;  num_q <= num_d;
    cnt_q  <= cnt_d;   rad_q <= rad_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[s_q[IDX_W-1:0]];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_chg_q, out_rad_q};

  a_ready_drops_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("Request accepted while the previous one is still in work.");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_Y) |-> (s_q >= 0 && s_q <= hi_q && s_q < live_s))
    else $error("Line walk left the slice range.");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q != ST_CLEAR) |-> s_ok)
    else $error("Profile write outside the slices in use.");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_RESP))
    else $error("Result shown without a finished request.");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the radius profile keeper: directed and random stream traffic against a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import plcm_pkg::*;

  typedef struct {
    logic signed [15:0] radius;
    logic [8:0]         changed;
  } outcome_t;

  class radius_scoreboard;
    logic signed [15:0] profile [MAX_SLICES_DEF];
    int unsigned        step_reg;
    int unsigned        siu_reg;
    int unsigned        irad_reg;
    outcome_t           awaited [$];
    int                 errors;

    function new();
      step_reg = STEP_RST;
      siu_reg  = SIU_RST;
      irad_reg = RADIUS_RST;
      errors   = 0;
      refill();
    endfunction

    function void refill();
      for (int i = 0; i < MAX_SLICES_DEF; i++) profile[i] = 16'(irad_reg);
    endfunction

    function int live();
      return (siu_reg > MAX_SLICES_DEF) ? MAX_SLICES_DEF : siu_reg;
    endfunction

    function void set_register(cfg_idx_e idx, int unsigned v);
      case (idx)
        CFG_SLICE_STEP:     step_reg = v & 'h3FF;
        CFG_SLICES_IN_USE:  siu_reg  = v & 'h1FF;
        CFG_INITIAL_RADIUS: irad_reg = v & 'h7FFF;
        default: ;
      endcase
    endfunction

    function int lower_at(int s, int y);
      if (s < 0 || s >= live()) return 0;
      if (int'(profile[s]) > y) begin
        profile[s] = y[15:0];
        return 1;
      end
      return 0;
    endfunction

    function int cut_span(int x1, int y1, int x2, int y2);
      int     st, s1, s2, xs, ys, xe, ye, lo, hi, n;
      longint dx, dy, k, y;
      st = (step_reg == 0) ? 1 : int'(step_reg);
      s1 = x1 / st;
      s2 = x2 / st;
      if (s1 == s2) return lower_at(s1, (y1 < y2) ? y1 : y2);
      if (s1 < s2) begin
        xs = s1; ys = y1; xe = s2; ye = y2;
      end else begin
        xs = s2; ys = y2; xe = s1; ye = y1;
      end
      dx = longint'(xe) - xs;
      dy = longint'(ye) - ys;
      lo = (xs < 0) ? 0 : xs;
      hi = (xe < live() - 1) ? xe : live() - 1;
      n = 0;
      for (int s = lo; s <= hi; s++) begin
        k = longint'(s) - xs;
        y = (longint'(ys) * dx + dy * k) / dx;
        n += lower_at(s, int'(y));
      end
      return n;
    endfunction

    function void note_request(func_e f, logic [63:0] d);
      outcome_t o;
      int       x1;
      o.radius  = '0;
      o.changed = '0;
      x1 = $signed(d[15:0]);
      case (f)
        FUNC_CUT:
          o.changed = 9'(cut_span(x1, $signed(d[31:16]), $signed(d[47:32]),
                                  $signed(d[63:48])));
        FUNC_RESTORE: refill();
        FUNC_READ: if (x1 >= 0 && x1 < live()) o.radius = profile[x1];
        default: ;
      endcase
      awaited.push_back(o);
    endfunction

    function void flag(string what, int want, int got);
      errors++;
      if (errors <= 10) $display("Mismatch in %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void check_result(logic [31:0] d);
      outcome_t o;
      if (awaited.size() == 0) begin
        flag("result with nothing pending", 0, int'(d));
        return;
      end
      o = awaited.pop_front();
      if (d[15:0] !== o.radius) flag("read_radius", o.radius, $signed(d[15:0]));
      if (d[24:16] !== o.changed) flag("slices_changed", o.changed, d[24:16]);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [63:0]           s_axis_tdata_i;
  logic [1:0]            s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [31:0]           m_axis_tdata_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  radius_scoreboard sb = new();
  int burst_left = 1;
  bit offering = 1'b0;
  bit rx_hold = 1'b0;

  profile_line_cut_min_update u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
    if (s_axis_tvalid_i && s_axis_tready_o) sb.note_request(func_e'(s_axis_tuser_i), s_axis_tdata_i);
  end

  initial begin : rx_pacing
    int mode, mode_left, stall_left, hold_left;
    mode = 0;
    mode_left = 0;
    stall_left = 0;
    hold_left = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold) begin
        rx_hold = 1'b0;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(64, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if ((mode == 1 && $urandom_range(0, 3) == 0) ||
                   (mode == 2 && $urandom_range(0, 9) < 6)) begin
        stall_left = $urandom_range(0, 7);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int any16();
    logic [15:0] r;
    r = 16'($urandom);
    return $signed(r);
  endfunction

  task automatic offer(func_e f, int x1, int y1, int x2, int y2);
    int gap;
    s_axis_tdata_i  <= {16'(y2), 16'(x2), 16'(y1), 16'(x1)};
    s_axis_tuser_i  <= f;
    s_axis_tvalid_i <= 1'b1;
    offering = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic settle();
    if (offering) begin
      s_axis_tvalid_i <= 1'b0;
      offering = 1'b0;
    end
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apply_setting(int step, int siu, int irad);
    logic [CFG_DATA_W-1:0] junk;
    settle();
    junk = CFG_DATA_W'($urandom);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SLICE_STEP;
    cfg_wdata_i <= CFG_DATA_W'(step);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SLICES_IN_USE;
    cfg_wdata_i <= CFG_DATA_W'(siu);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_INITIAL_RADIUS;
    cfg_wdata_i <= CFG_DATA_W'(irad);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_UNUSED;
    cfg_wdata_i <= junk;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_register(CFG_SLICE_STEP, step);
    sb.set_register(CFG_SLICES_IN_USE, siu);
    sb.set_register(CFG_INITIAL_RADIUS, irad);
  endtask

  task automatic random_items(int count);
    int pick, st, lv, c, w, x1, x2, y1, y2, irad;
    for (int i = 0; i < count; i++) begin
      st   = (sb.step_reg == 0) ? 1 : int'(sb.step_reg);
      lv   = sb.live();
      irad = sb.irad_reg;
      pick = $urandom_range(0, 99);
      y1 = any16();
      y2 = any16();
      x2 = any16();
      if (pick < 62) begin
        if ($urandom_range(0, 9) == 0) begin
          x1 = any16();
        end else begin
          c  = (int'($urandom_range(0, lv + 8)) - 4) * st + int'($urandom_range(0, st - 1));
          w  = int'($urandom_range(0, 12)) * st;
          x1 = clamp16(c + int'($urandom_range(0, 2 * w)) - w);
          x2 = clamp16(c + int'($urandom_range(0, 2 * w)) - w);
        end
        if ($urandom_range(0, 6) != 0) begin
          y1 = clamp16(irad - 300 + int'($urandom_range(0, 400)));
          y2 = clamp16(irad - 300 + int'($urandom_range(0, 400)));
        end
        offer(FUNC_CUT, x1, y1, x2, y2);
      end else if (pick < 90) begin
        x1 = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, lv + 2)) - 1 : any16();
        offer(FUNC_READ, x1, y1, x2, y2);
      end else if (pick < 96) begin
        offer(FUNC_RESTORE, any16(), y1, x2, y2);
      end else begin
        offer(FUNC_NONE, any16(), y1, x2, y2);
      end
    end
  endtask

  initial begin : stimulus
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = FUNC_CUT;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_SLICE_STEP;
    cfg_wdata_i     = '0;
    rst_ni          = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    offer(FUNC_READ, 0, any16(), any16(), any16());
    offer(FUNC_READ, -1, 0, 0, 0);
    offer(FUNC_READ, 256, 0, 0, 0);
    offer(FUNC_CUT, 5, 50, 5, 30);
    offer(FUNC_CUT, 10, 90, 20, 40);
    offer(FUNC_CUT, 30, -10, 25, 60);
    offer(FUNC_CUT, -32768, -32768, 32767, 32767);
    offer(FUNC_CUT, 32767, 0, 300, 5);
    offer(FUNC_NONE, any16(), any16(), any16(), any16());
    offer(FUNC_READ, 5, 0, 0, 0);
    offer(FUNC_READ, 255, 0, 0, 0);
    offer(FUNC_RESTORE, 0, 0, 0, 0);
    offer(FUNC_CUT, 0, 32767, 1, -32768);
    offer(FUNC_READ, 1, 0, 0, 0);

    apply_setting(0, 511, 32767);
    offer(FUNC_RESTORE, 0, 0, 0, 0);
    offer(FUNC_READ, 255, 0, 0, 0);
    offer(FUNC_READ, 256, 0, 0, 0);
    random_items(14);

    apply_setting(1023, 1, 0);
    offer(FUNC_RESTORE, 0, 0, 0, 0);
    offer(FUNC_CUT, -1023, -5, 1023, -9);
    offer(FUNC_READ, 0, 0, 0, 0);
    offer(FUNC_READ, 32767, 0, 0, 0);
    random_items(10);

    apply_setting(7, 40, 500);
    offer(FUNC_RESTORE, 0, 0, 0, 0);
    offer(FUNC_CUT, -6, 10, 6, 20);
    offer(FUNC_CUT, -8, 300, 20, 100);
    offer(FUNC_READ, -32768, 0, 0, 0);
    // Hold the result side off while requests keep coming, so the block backs up.
    rx_hold = 1'b1;
    burst_left = 8;
    for (int i = 0; i < 6; i++) offer(FUNC_READ, i, any16(), any16(), any16());
    random_items(24);

    apply_setting(3, 0, 1000);
    offer(FUNC_CUT, 0, 0, 30, 0);
    offer(FUNC_READ, 0, 0, 0, 0);
    random_items(8);

    apply_setting(1, 256, 12345);
    offer(FUNC_RESTORE, 0, 0, 0, 0);
    random_items(20);

    settle();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("profile_line_cut_min_update verification clean");
    end else begin
      $display("profile_line_cut_min_update verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #25_000_000;
    $display("profile_line_cut_min_update verification failed");
    $finish;
  end

endmodule
